// ===== sv/differential_drive_odometry_assert.svh =====
// Assertion macros for the differential drive odometry block.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ddo assertion failed");
`define DDO_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ddo assertion failed");
`else
`define DDO_ASSERT(lbl, prop)
`define DDO_NEVER(lbl, cond)
`endif
`endif

// ===== sv/ddo_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, CORDIC arctangent table and fixed-point helpers.
// No dependencies.
package ddo_pkg;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int MUL_W = 35;

	localparam logic signed [42:0] PI_Q24 = 43'sd52707179;
	localparam logic signed [42:0] TWO_PI_Q24 = 43'sd105414357;
	localparam logic signed [32:0] HALF_PI_Q24 = 33'sd26353589;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [24:0] ATAN_TAB [32] = '{
		25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331,
		25'd1047214, 25'd524117, 25'd262123, 25'd131069,
		25'd65536, 25'd32768, 25'd16384, 25'd8192,
		25'd4096, 25'd2048, 25'd1024, 25'd512,
		25'd256, 25'd128, 25'd64, 25'd32,
		25'd16, 25'd8, 25'd4, 25'd2,
		25'd1, 25'd0, 25'd0, 25'd0,
		25'd0, 25'd0, 25'd0, 25'd0
	};

	typedef struct packed {
		logic signed [42:0] h;
		logic inc;
		logic dec;
	} wrap_t;

	function automatic wrap_t wrap_once(input logic signed [42:0] h);
		wrap_t w;
		w.h = h;
		w.inc = 1'b0;
		w.dec = 1'b0;
		if (h > PI_Q24) begin
			w.h = h - TWO_PI_Q24;
			w.inc = 1'b1;
		end else if (h <= -PI_Q24) begin
			w.h = h + TWO_PI_Q24;
			w.dec = 1'b1;
		end
		return w;
	endfunction

	function automatic logic signed [15:0] turn_step(input logic signed [15:0] t,
		input logic inc, input logic dec);
		logic signed [15:0] r;
		r = t;
		if (inc && t != 16'sh7fff)
			r = t + 16'sd1;
		else if (dec && t != -16'sh8000)
			r = t - 16'sd1;
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		logic signed [31:0] r;
		if (v > 43'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -43'sd2147483648)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32_prod(input logic signed [2*MUL_W-1:0] v);
		logic signed [31:0] r;
		if (v > 33'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -33'sd2147483648)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction
endpackage

// ===== sv/differential_drive_odometry.sv =====
`timescale 1ns / 1ps
// Differential drive odometry top: sequencer around one shared multiplier and CORDIC.
// A set word goes from S_IDLE straight to S_DONE; an update word runs S_DL to S_MY, waiting in S_CORD for the CORDIC.
// Throughput: one word at a time; the shared multiplier and the iterative CORDIC set it.
// A finished word waits in the output register while the next word is taken.
// Reset (arst_n, async, active low) clears pose, speeds, history and config defaults.
`include "differential_drive_odometry_assert.svh"
module differential_drive_odometry (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic signed [31:0] set_x,
	input  logic signed [31:0] set_y,
	input  logic signed [31:0] set_heading,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [15:0] turn_count,
	output logic signed [31:0] left_speed,
	output logic signed [31:0] right_speed
);
	import ddo_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DL   = 4'd1;
	localparam logic [3:0] S_DR   = 4'd2;
	localparam logic [3:0] S_SPL  = 4'd3;
	localparam logic [3:0] S_SPR  = 4'd4;
	localparam logic [3:0] S_HWH  = 4'd5;
	localparam logic [3:0] S_HWL  = 4'd6;
	localparam logic [3:0] S_HEAD = 4'd7;
	localparam logic [3:0] S_WRAP = 4'd8;
	localparam logic [3:0] S_CST  = 4'd9;
	localparam logic [3:0] S_CORD = 4'd10;
	localparam logic [3:0] S_MC   = 4'd11;
	localparam logic [3:0] S_MS   = 4'd12;
	localparam logic [3:0] S_MY   = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	localparam logic [2:0] R_KL   = 3'd0;
	localparam logic [2:0] R_KR   = 3'd1;
	localparam logic [2:0] R_INV  = 3'd2;
	localparam logic [2:0] R_RATE = 3'd3;
	localparam logic [2:0] R_WRAP = 3'd4;

	logic [3:0] state_q;
	logic [31:0] kl_q, kr_q, inv_q;
	logic [15:0] rate_q;
	logic wrap_q;

	logic signed [31:0] x_q, y_q, hd_q, prevh_q, spdl_q, spdr_q;
	logic signed [15:0] turns_q;
	logic [31:0] prevl_q, prevr_q, lt_q, rt_q;

	logic signed [55:0] dl_q, dr_q;
	logic [56:0] m_q;
	logic neg_q, big_q;
	logic [31:0] hwlo_q;
	logic signed [41:0] hdel_q;
	logic signed [33:0] dd_q;

	logic out_valid_q;
	logic signed [31:0] o_x_q, o_y_q, o_h_q, o_sl_q, o_sr_q;
	logic signed [15:0] o_t_q;

	logic signed [MUL_W-1:0] ma, mb;
	logic signed [2*MUL_W-1:0] pv;
	logic signed [2*MUL_W-1:0] pv8, pv30;
	logic signed [32:0] clk_dl, clk_dr;
	logic signed [56:0] diff, dsum, dhalf;
	logic signed [33:0] ddc;
	logic [40:0] rsum, rmag;
	logic signed [42:0] h43, xs43, ys43, seth43;
	wrap_t wu, ws;
	logic cstart, cdone;
	logic signed [32:0] ccos, csin;
	logic signed [31:0] cang;
	logic signed [32:0] hsum;
	logic accept, load_out;

	ddo_mul u_mul (
		.clk  (clk),
		.a    (ma),
		.b    (mb),
		.prod (pv)
	);

	ddo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart),
		.ang    (cang),
		.done   (cdone),
		.cos_o  (ccos),
		.sin_o  (csin)
	);

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		pv8 = pv >>> 8;
		pv30 = pv >>> 30;
		if (dl_q > 56'sd2147483648)
			clk_dl = 33'sd2147483647 + 33'sd1;
		else if (dl_q < -56'sd2147483649)
			clk_dl = -33'sd2147483648 - 33'sd1;
		else
			clk_dl = dl_q[32:0];
		if (dr_q > 56'sd2147483648)
			clk_dr = 33'sd2147483647 + 33'sd1;
		else if (dr_q < -56'sd2147483649)
			clk_dr = -33'sd2147483648 - 33'sd1;
		else
			clk_dr = dr_q[32:0];
		diff = 57'(dr_q) - 57'(dl_q);
		dsum = 57'(dl_q) + 57'(dr_q);
		dhalf = dsum >>> 1;
		if (dhalf > 57'sd4294967296)
			ddc = 34'sd4294967295 + 34'sd1;
		else if (dhalf < -57'sd4294967296)
			ddc = -34'sd4294967295 - 34'sd1;
		else
			ddc = dhalf[33:0];
		rsum = {1'b0, hwlo_q, 8'b0} + {1'b0, pv[63:24]};
		rmag = (big_q || rsum > 41'h100_0000_0000) ? 41'h100_0000_0000 : rsum;
		h43 = 43'(hd_q) + 43'(hdel_q);
		wu = wrap_once(h43);
		seth43 = 43'(set_heading);
		ws = wrap_once(seth43);
		xs43 = 43'(x_q) + 43'($signed(pv30[39:0]));
		ys43 = 43'(y_q) + 43'($signed(pv30[39:0]));
		hsum = 33'(hd_q) + 33'(prevh_q);
		cang = 32'(hsum >>> 1);
		cstart = (state_q == S_CST);
	end

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_DL: begin
				ma = MUL_W'($signed(lt_q - prevl_q));
				mb = $signed({3'b0, kl_q});
			end
			S_DR: begin
				ma = MUL_W'($signed(rt_q - prevr_q));
				mb = $signed({3'b0, kr_q});
			end
			S_SPL: begin
				ma = MUL_W'(clk_dl);
				mb = $signed({19'b0, rate_q});
			end
			S_SPR: begin
				ma = MUL_W'(clk_dr);
				mb = $signed({19'b0, rate_q});
			end
			S_HWH: begin
				ma = $signed({10'b0, m_q[56:32]});
				mb = $signed({3'b0, inv_q});
			end
			S_HWL: begin
				ma = $signed({3'b0, m_q[31:0]});
				mb = $signed({3'b0, inv_q});
			end
			S_MC: begin
				ma = MUL_W'(dd_q);
				mb = MUL_W'(ccos);
			end
			S_MS: begin
				ma = MUL_W'(dd_q);
				mb = MUL_W'(csin);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kl_q <= 32'd1677722;
			kr_q <= 32'd1677722;
			inv_q <= 32'd21474836;
			rate_q <= 16'd100;
			wrap_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				R_KL: kl_q <= cfg_wdata;
				R_KR: kr_q <= cfg_wdata;
				R_INV: inv_q <= cfg_wdata;
				R_RATE: rate_q <= cfg_wdata[15:0];
				R_WRAP: wrap_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q <= '0;
			y_q <= '0;
			hd_q <= '0;
			turns_q <= '0;
			prevl_q <= '0;
			prevr_q <= '0;
			prevh_q <= '0;
			spdl_q <= '0;
			spdr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type) begin
							x_q <= set_x;
							y_q <= set_y;
							hd_q <= sat32(ws.h);
							turns_q <= turn_step(turns_q, ws.inc, ws.dec);
							state_q <= S_DONE;
						end else begin
							state_q <= S_DL;
						end
					end
				end
				S_DL: state_q <= S_DR;
				S_DR: state_q <= S_SPL;
				S_SPL: state_q <= S_SPR;
				S_SPR: begin
					spdl_q <= sat32_prod(pv);
					state_q <= S_HWH;
				end
				S_HWH: begin
					spdr_q <= sat32_prod(pv);
					state_q <= S_HWL;
				end
				S_HWL: state_q <= S_HEAD;
				S_HEAD: state_q <= S_WRAP;
				S_WRAP: begin
					if (wrap_q) begin
						hd_q <= sat32(wu.h);
						turns_q <= turn_step(turns_q, wu.inc, wu.dec);
					end else begin
						hd_q <= sat32(h43);
					end
					state_q <= S_CST;
				end
				S_CST: state_q <= S_CORD;
				S_CORD: begin
					if (cdone)
						state_q <= S_MC;
				end
				S_MC: state_q <= S_MS;
				S_MS: begin
					x_q <= sat32(xs43);
					state_q <= S_MY;
				end
				S_MY: begin
					y_q <= sat32(ys43);
					prevl_q <= lt_q;
					prevr_q <= rt_q;
					prevh_q <= hd_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lt_q <= left_count;
			rt_q <= right_count;
		end
		if (state_q == S_DR)
			dl_q <= pv8[55:0];
		if (state_q == S_SPL)
			dr_q <= pv8[55:0];
		if (state_q == S_SPR) begin
			neg_q <= diff[56];
			m_q <= diff[56] ? 57'(-diff) : 57'(diff);
		end
		if (state_q == S_HWL) begin
			big_q <= |pv[69:32];
			hwlo_q <= pv[31:0];
		end
		if (state_q == S_HEAD) begin
			hdel_q <= neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
			dd_q <= ddc;
		end
		if (load_out) begin
			o_x_q <= x_q;
			o_y_q <= y_q;
			o_h_q <= hd_q;
			o_t_q <= turns_q;
			o_sl_q <= spdl_q;
			o_sr_q <= spdr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = o_x_q;
	assign pos_y = o_y_q;
	assign heading = o_h_q;
	assign turn_count = o_t_q;
	assign left_speed = o_sl_q;
	assign right_speed = o_sr_q;

	`DDO_ASSERT(a_busy_after_accept, accept |=> in_stall)
	`DDO_ASSERT(a_done_only_waiting, cdone |-> state_q == S_CORD)
	`DDO_ASSERT(a_load_sets_valid, load_out |=> out_valid)
	`DDO_NEVER(a_no_start_while_waiting, cstart && cdone)
endmodule

// ===== sv/ddo_mul.sv =====
`timescale 1ns / 1ps
// Shared registered signed multiplier for the odometry sequencer.
// Depends on ddo_pkg.
module ddo_mul (
	input  logic clk,
	input  logic signed [ddo_pkg::MUL_W-1:0] a,
	input  logic signed [ddo_pkg::MUL_W-1:0] b,
	output logic signed [2*ddo_pkg::MUL_W-1:0] prod
);
	import ddo_pkg::*;

	logic signed [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign prod = p_q;
endmodule

// ===== sv/ddo_cordic.sv =====
`timescale 1ns / 1ps
// Iterative sin/cos: angle reduction by shift-subtract, fold, CORDIC rotations.
// Depends on ddo_pkg.
module ddo_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] ang,
	output logic done,
	output logic signed [32:0] cos_o,
	output logic signed [32:0] sin_o
);
	import ddo_pkg::*;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RED  = 2'd1;
	localparam logic [1:0] C_FOLD = 2'd2;
	localparam logic [1:0] C_ROT  = 2'd3;
	localparam logic [CORDIC_IW-1:0] LAST = CORDIC_IW'(CORDIC_STEPS - 1);

	logic [1:0] st_q;
	logic [2:0] k_q;
	logic [CORDIC_IW-1:0] i_q;
	logic done_q;
	logic neg_q, flip_q;
	logic [31:0] mag_q;
	logic signed [32:0] r_q, x_q, y_q;
	logic [32:0] sub_v;
	logic signed [32:0] rr, rf;
	logic fl;
	logic signed [32:0] xs, ys, at;

	always_comb begin
		sub_v = 33'(TWO_PI_Q24[31:0]) << k_q;
		rr = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		if (rr > 33'(PI_Q24))
			rr = rr - 33'(TWO_PI_Q24);
		else if (rr <= -33'(PI_Q24))
			rr = rr + 33'(TWO_PI_Q24);
		rf = rr;
		fl = 1'b0;
		if (rr > HALF_PI_Q24) begin
			rf = rr - 33'(PI_Q24);
			fl = 1'b1;
		end else if (rr < -HALF_PI_Q24) begin
			rf = rr + 33'(PI_Q24);
			fl = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = $signed({8'b0, ATAN_TAB[5'(i_q)]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				C_IDLE: begin
					if (start)
						st_q <= C_RED;
				end
				C_RED: begin
					if (k_q == 3'd0)
						st_q <= C_FOLD;
				end
				C_FOLD: st_q <= C_ROT;
				C_ROT: begin
					if (i_q == LAST) begin
						st_q <= C_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				neg_q <= ang[31];
				mag_q <= ang[31] ? 32'(-ang) : 32'(ang);
				k_q <= 3'd4;
			end
			C_RED: begin
				if ({1'b0, mag_q} >= sub_v)
					mag_q <= 32'({1'b0, mag_q} - sub_v);
				k_q <= k_q - 3'd1;
			end
			C_FOLD: begin
				r_q <= rf;
				flip_q <= fl;
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				i_q <= '0;
			end
			default: begin
				if (!r_q[32]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					r_q <= r_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					r_q <= r_q + at;
				end
				i_q <= i_q + 1'b1;
			end
		endcase
	end

	assign done = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;
endmodule
